// ===== rtl/fdt_pkg.sv =====
// ----------------------------------------------------------------------------
// fdt_pkg: flat directory table engine package
// Shared types, codes and helper functions for the directory engine.
// ----------------------------------------------------------------------------
package fdt_pkg;

	// fixed geometry of the file system
	localparam int NAME_BYTES   = 8;
	localparam int SECTOR_BYTES = 512;
	localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
	localparam int DATA_START   = 2;

	// field widths
	localparam int NAME_W   = 64;
	localparam int BYTES_W  = 32;
	localparam int SECTOR_W = 32;
	localparam int SPAN_W   = 24;
	localparam int SLOT_W   = 4;
	localparam int FILES_W  = 5;
	localparam int STATUS_W = 2;

	localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 32'd65536;

	// request codes
	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_READ   = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_LIST   = 2'd3
	} req_op_t;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FAIL   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EXISTS = 2'd2;

	// input transaction
	typedef struct packed {
		req_op_t              req_type;
		logic [NAME_W-1:0]    file_name;
		logic [BYTES_W-1:0]   byte_count;
	} req_t;

	// output transaction
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_W-1:0]    slot_index;
		logic [NAME_W-1:0]    entry_name;
		logic [BYTES_W-1:0]   file_bytes;
		logic [SECTOR_W-1:0]  first_sector;
		logic [SPAN_W-1:0]    sector_span;
		logic [FILES_W-1:0]   files_present;
		logic                 last;
	} rsp_t;

	// one directory slot as stored in memory
	typedef struct packed {
		logic [NAME_W-1:0]    label;
		logic [BYTES_W-1:0]   length;
		logic [SECTOR_W-1:0]  start;
	} entry_t;

	// store controls from the sequencer
	typedef struct packed {
		logic wr_en;
		logic set_used;
		logic clr_used;
	} store_ctl_t;

	// canonical name and whether it is terminated in time
	typedef struct packed {
		logic [NAME_W-1:0] name;
		logic              ok;
	} canon_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_COMPARE,
		S_COMMIT,
		S_FOUND,
		S_EMIT
	} seq_state_t;

	// zero everything above the first zero byte
	function automatic canon_t name_canon(input logic [NAME_W-1:0] n);
		canon_t c;
		logic   ended;
		c.name = '0;
		c.ok   = 1'b0;
		ended  = 1'b0;
		for (int i = 0; i < NAME_W / 8; i++) begin
			if (n[8*i +: 8] == 8'd0) begin
				ended = 1'b1;
				if (i < NAME_BYTES)
					c.ok = 1'b1;
			end
			if (!ended)
				c.name[8*i +: 8] = n[8*i +: 8];
		end
		return c;
	endfunction

	// ceil(bytes / SECTOR_BYTES), low SPAN_W bits
	function automatic logic [SPAN_W-1:0] sectors_for(input logic [BYTES_W-1:0] b);
		logic [BYTES_W:0] q;
		q = {1'b0, b >> SECTOR_SHIFT} + (BYTES_W + 1)'(|b[SECTOR_SHIFT-1:0]);
		return q[SPAN_W-1:0];
	endfunction

	// sectors handed out for a file, never fewer than one
	function automatic logic [SPAN_W-1:0] alloc_span(input logic [BYTES_W-1:0] b);
		logic [SPAN_W-1:0] s;
		s = sectors_for(b);
		if (b == '0)
			s = SPAN_W'(1);
		return s;
	endfunction

endpackage

// ===== rtl/fdt_store.sv =====
// ----------------------------------------------------------------------------
// fdt_store: directory slot storage
// Single-port slot memory with registered read, plus per-slot used flags.
// ----------------------------------------------------------------------------
module fdt_store #(
	parameter int MAX_ENTRIES = 16,
	localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fdt_pkg::store_ctl_t  ctl,
	input  logic [IDX_W-1:0]     addr,
	input  fdt_pkg::entry_t      wdata,
	output fdt_pkg::entry_t      rd_data,
	output logic                 rd_used,
	output logic [MAX_ENTRIES-1:0] used_vec
);
	import fdt_pkg::*;

	entry_t                 mem [MAX_ENTRIES];
	entry_t                 rd_data_q;
	logic [MAX_ENTRIES-1:0] used_q;
	logic                   rd_used_q;

	// slot memory, contents undefined until written
	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			mem[addr] <= wdata;
		rd_data_q <= mem[addr];
	end

	// used flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			if (ctl.set_used)
				used_q[addr] <= 1'b1;
			else if (ctl.clr_used)
				used_q[addr] <= 1'b0;
			rd_used_q <= used_q[addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_used  = rd_used_q;
	assign used_vec = used_q;

`ifndef ASSERT_OFF
	// a slot is never claimed and freed at once
	a_set_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.set_used && ctl.clr_used))
		else $error("slot set and cleared in the same cycle");

	// only a free slot is allocated
	a_set_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.set_used |-> !used_q[addr])
		else $error("allocation into a used slot");

	// only a used slot is deleted
	a_clr_used: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr_used |-> used_q[addr])
		else $error("delete of a free slot");
`endif

endmodule

// ===== rtl/fdt_seq.sv =====
// ----------------------------------------------------------------------------
// fdt_seq: directory request sequencer
// Scans the slots one at a time through a shared comparator and builds
// the result transactions into an output register.
// ----------------------------------------------------------------------------
module fdt_seq #(
	parameter int MAX_ENTRIES = 16,
	localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  fdt_pkg::req_t          req_data,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output fdt_pkg::rsp_t          rsp_data,
	input  logic [31:0]            max_bytes,
	output fdt_pkg::store_ctl_t    st_ctl,
	output logic [IDX_W-1:0]       st_addr,
	output fdt_pkg::entry_t        st_wdata,
	input  fdt_pkg::entry_t        rd_data,
	input  logic                   rd_used,
	input  logic [MAX_ENTRIES-1:0] used_vec
);
	import fdt_pkg::*;

	localparam int TOT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

	seq_state_t          state_q, state_d;
	req_op_t             op_q;
	logic [NAME_W-1:0]   name_q;
	logic                name_ok_q;
	logic [BYTES_W-1:0]  count_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    slot_q;
	logic                free_found_q;
	logic [SECTOR_W-1:0] ptr_q;
	logic [TOT_W-1:0]    total_q;
	rsp_t                res_q, res_d;
	logic                res_ld;
	rsp_t                out_q;
	logic                out_valid_q;

	logic                acc;
	logic                out_free;
	logic                at_end;
	logic                hit;
	logic                free_any;
	logic                fail_pre;
	logic [NAME_W-1:0]   cmp_a, cmp_b;
	logic                cmp_eq, cmp_lt;
	logic [BYTES_W-1:0]  rd_size;
	canon_t              canon;

	assign acc       = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !rsp_stall;
	assign at_end    = (idx_q == LAST_IDX);
	assign canon     = name_canon(req_data.file_name);

	// shared comparator, operands chosen by the state
	always_comb begin
		case (state_q)
			S_CHECK: begin
				cmp_a = NAME_W'(max_bytes);
				cmp_b = NAME_W'(count_q);
			end
			S_COMPARE: begin
				cmp_a = rd_data.label;
				cmp_b = name_q;
			end
			S_FOUND: begin
				cmp_a = NAME_W'(rd_data.length);
				cmp_b = NAME_W'(count_q);
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
	end
	assign cmp_eq = (cmp_a == cmp_b);
	assign cmp_lt = (cmp_a < cmp_b);

	assign hit      = rd_used && cmp_eq;
	assign free_any = free_found_q || !rd_used;
	assign fail_pre = ((op_q == REQ_CREATE) && (!name_ok_q || cmp_lt)) ||
	                  ((op_q == REQ_LIST) && (used_vec == '0));
	assign rd_size  = cmp_lt ? rd_data.length : count_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = fail_pre ? S_EMIT : S_READ;
			end
			S_READ: begin
				state_d = S_COMPARE;
			end
			S_COMPARE: begin
				case (op_q)
					REQ_CREATE: begin
						if (hit)
							state_d = S_EMIT;
						else if (at_end)
							state_d = free_any ? S_COMMIT : S_EMIT;
						else
							state_d = S_READ;
					end
					REQ_READ: begin
						if (hit)
							state_d = S_FOUND;
						else if (at_end)
							state_d = S_EMIT;
						else
							state_d = S_READ;
					end
					REQ_DELETE: begin
						if (hit || at_end)
							state_d = S_EMIT;
						else
							state_d = S_READ;
					end
					REQ_LIST: begin
						if (rd_used)
							state_d = S_EMIT;
						else if (at_end)
							state_d = S_IDLE;
						else
							state_d = S_READ;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_COMMIT: begin
				state_d = S_EMIT;
			end
			S_FOUND: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free)
					state_d = res_q.last ? S_IDLE : S_READ;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// store controls and result assembly
	always_comb begin
		st_ctl   = '0;
		st_addr  = idx_q;
		st_wdata = '{label: name_q, length: count_q, start: ptr_q};
		res_ld   = 1'b0;
		res_d    = '0;
		res_d.status        = STAT_FAIL;
		res_d.files_present = FILES_W'(total_q);
		res_d.last          = 1'b1;
		case (state_q)
			S_CHECK: begin
				res_ld = fail_pre;
			end
			S_COMPARE: begin
				case (op_q)
					REQ_CREATE: begin
						if (hit) begin
							res_ld       = 1'b1;
							res_d.status = STAT_EXISTS;
						end else if (at_end && !free_any) begin
							res_ld = 1'b1;
						end
					end
					REQ_READ: begin
						res_ld = at_end && !hit;
					end
					REQ_DELETE: begin
						if (hit) begin
							st_ctl.clr_used     = 1'b1;
							res_ld              = 1'b1;
							res_d.status        = STAT_OK;
							res_d.slot_index    = SLOT_W'(idx_q);
							res_d.entry_name    = rd_data.label;
							res_d.file_bytes    = rd_data.length;
							res_d.first_sector  = rd_data.start;
							res_d.files_present = FILES_W'(total_q - TOT_W'(1));
						end else if (at_end) begin
							res_ld = 1'b1;
						end
					end
					REQ_LIST: begin
						if (rd_used) begin
							res_ld             = 1'b1;
							res_d.status       = STAT_OK;
							res_d.slot_index   = SLOT_W'(idx_q);
							res_d.entry_name   = rd_data.label;
							res_d.file_bytes   = rd_data.length;
							res_d.first_sector = rd_data.start;
							res_d.sector_span  = alloc_span(rd_data.length);
							// final entry when no used slot lies above this one
							res_d.last         = ~|((used_vec >> idx_q) >> 1);
						end
					end
					default: res_ld = 1'b0;
				endcase
			end
			S_COMMIT: begin
				st_addr             = slot_q;
				st_ctl.wr_en        = 1'b1;
				st_ctl.set_used     = 1'b1;
				res_ld              = 1'b1;
				res_d.status        = STAT_OK;
				res_d.slot_index    = SLOT_W'(slot_q);
				res_d.entry_name    = name_q;
				res_d.file_bytes    = count_q;
				res_d.first_sector  = ptr_q;
				res_d.sector_span   = alloc_span(count_q);
				res_d.files_present = FILES_W'(total_q + TOT_W'(1));
			end
			S_FOUND: begin
				res_ld             = 1'b1;
				res_d.status       = STAT_OK;
				res_d.slot_index   = SLOT_W'(idx_q);
				res_d.entry_name   = rd_data.label;
				res_d.file_bytes   = rd_size;
				res_d.first_sector = rd_data.start;
				res_d.sector_span  = sectors_for(rd_size);
			end
			default: res_ld = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			ptr_q        <= SECTOR_W'(DATA_START);
			total_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHECK) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
			end else if ((state_q == S_COMPARE || state_q == S_EMIT) && state_d == S_READ) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (state_q == S_COMPARE && !rd_used)
				free_found_q <= 1'b1;
			if (state_q == S_COMMIT) begin
				ptr_q   <= ptr_q + SECTOR_W'(alloc_span(count_q));
				total_q <= total_q + TOT_W'(1);
			end else if (st_ctl.clr_used) begin
				total_q <= total_q - TOT_W'(1);
			end
			if (state_q == S_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	// request capture, lowest free slot, pending result and output register
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q      <= req_data.req_type;
			name_q    <= canon.name;
			name_ok_q <= canon.ok;
			count_q   <= req_data.byte_count;
		end
		if (state_q == S_COMPARE && !rd_used && !free_found_q)
			slot_q <= idx_q;
		if (res_ld)
			res_q <= res_d;
		if (state_q == S_EMIT && out_free)
			out_q <= res_q;
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

`ifndef ASSERT_OFF
	// file count tracks the used flags
	a_total_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_vec) == int'(total_q))
		else $error("file count disagrees with used flags");

	// an accepted transaction starts the checks
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == S_CHECK))
		else $error("accepted transaction did not start");

	// an emitted result lands in the output register
	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> (rsp_valid && rsp_data.last == $past(res_q.last)))
		else $error("result not loaded into output register");

	// the sector pointer moves only on a create
	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_COMMIT) |=> $stable(ptr_q))
		else $error("sector pointer moved outside a create");
`endif

endmodule

// ===== rtl/flat_directory_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// flat_directory_table_engine_top: flat directory table engine
// Create, read lookup, delete and list over a fixed slot directory with
// contiguous bump-pointer sector allocation.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------
//  request  | req_valid/req_stall | req_data (fdt_pkg::req_t)
//  result   | rsp_valid/rsp_stall | rsp_data (fdt_pkg::rsp_t)
//  config   | cfg_we              | cfg_wdata (max_file_bytes)
//
//  A full slot scan reads and compares every slot in order, a create that commits
//  also passes through the commit state, and a hit ends the scan early.
//  A list stops at the highest used slot and passes the emit state per entry.
//  Each slot goes through a registered memory read, then the shared comparator.
//  Reset clears the used flags at once; there is no clearing pass.
//  A stalled result holds in the output register while the next request runs.
// ----------------------------------------------------------------------------
module flat_directory_table_engine_top #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fdt_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fdt_pkg::rsp_t  rsp_data,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata
);
	import fdt_pkg::*;

	localparam int IDX_W = $clog2(MAX_ENTRIES);

	logic [BYTES_W-1:0]     max_bytes_q;
	store_ctl_t             st_ctl;
	logic [IDX_W-1:0]       st_addr;
	entry_t                 st_wdata;
	entry_t                 rd_data;
	logic                   rd_used;
	logic [MAX_ENTRIES-1:0] used_vec;

	// file length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_bytes_q <= MAX_BYTES_RESET;
		else if (cfg_we)
			max_bytes_q <= cfg_wdata;
	end

	// request sequencer
	fdt_seq #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.max_bytes (max_bytes_q),
		.st_ctl    (st_ctl),
		.st_addr   (st_addr),
		.st_wdata  (st_wdata),
		.rd_data   (rd_data),
		.rd_used   (rd_used),
		.used_vec  (used_vec)
	);

	// slot storage
	fdt_store #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (st_ctl),
		.addr     (st_addr),
		.wdata    (st_wdata),
		.rd_data  (rd_data),
		.rd_used  (rd_used),
		.used_vec (used_vec)
	);

endmodule
